// File: rtl/csim_pkg.sv
package csim_pkg;

  localparam int CSIM_MAX_LEN = 1024;

  // Squared-norm accumulator width: one Q2.30 square plus growth for max_len terms.
  function automatic int csim_norm_width(input int max_len);
    return 31 + $clog2(max_len);
  endfunction

endpackage

// File: rtl/cosine_similarity_engine.sv
// Streaming cosine similarity. Element pairs (x, y, Q1.15) arrive on the slave stream with
// tlast on the final pair; each pair is folded into a dot product and two squared norms by a
// single shared multiplier; ready stays low until the pair is folded in, so no new pair is
// taken meanwhile. After the last pair, unless a norm is zero, the block takes two integer
// square roots on one iterative unit, forms the norm product on the same multiplier and,
// unless the quotient would overflow, runs a 16-step restoring divide. The result is rounded
// to nearest Q1.15 and saturated to [-32768, 32767]; a zero norm gives 0 with tuser set.
// Accumulators are exact up to MAX_LEN pairs and wrap beyond. The next vector may start
// while a result still waits on the master side.
module cosine_similarity_engine
  import csim_pkg::*;
#(
  parameter int MAX_LEN = CSIM_MAX_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] x_elem, [31:16] y_elem
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] similarity
  output logic        m_axis_tuser    // [0] zero_norm
);

  localparam int NORM_W = csim_norm_width(MAX_LEN);
  localparam int DOT_W  = NORM_W + 1;
  localparam int ROOT_W = (NORM_W + 1) / 2;
  localparam int MUL_W  = ROOT_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int D_W    = 2 * ROOT_W;
  localparam int DEN_W  = D_W + 1;
  localparam int NUM_W  = DOT_W + 17;
  localparam int HI_W   = NUM_W - 16;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MAC  = 4'd1;
  localparam logic [3:0] S_CHK  = 4'd2;
  localparam logic [3:0] S_SQX  = 4'd3;
  localparam logic [3:0] S_SQY  = 4'd4;
  localparam logic [3:0] S_MULD = 4'd5;
  localparam logic [3:0] S_NUM  = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  localparam logic [15:0] SIM_MAX = 16'h7FFF;
  localparam logic [15:0] SIM_MIN = 16'h8000;

  logic [3:0]               state;
  logic [3:0]               state_next;
  logic [1:0]               phase;
  logic [3:0]               cnt;

  logic signed [15:0]       xr;
  logic signed [15:0]       yr;
  logic                     lastr;

  logic [DOT_W-1:0]         dot_acc;
  logic [NORM_W-1:0]        norm_x_acc;
  logic [NORM_W-1:0]        norm_y_acc;

  logic signed [MUL_W-1:0]  mul_a;
  logic signed [MUL_W-1:0]  mul_b;
  logic signed [PROD_W-1:0] prod;

  logic [ROOT_W-1:0]        sx;
  logic [ROOT_W-1:0]        sy;
  logic                     sq_start;
  logic                     sq_done;
  logic [ROOT_W-1:0]        sq_root;
  logic [NORM_W-1:0]        sq_in;

  logic                     neg;
  logic                     zf;
  logic                     ovf;
  logic [DEN_W-1:0]         den;
  logic [DEN_W-1:0]         rem;
  logic [15:0]              nlo;
  logic [15:0]              q;

  logic [DOT_W-1:0]         mag;
  logic [NUM_W-1:0]         num;
  logic [HI_W-1:0]          hi;
  logic                     hi_ovf;
  logic [DEN_W:0]           div_trial;
  logic                     div_fits;
  logic                     zero_in;
  logic                     out_load;
  logic [15:0]              sim;

  csim_isqrt #(
    .NORM_W (NORM_W),
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_in),
    .done     (sq_done),
    .root     (sq_root)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign zero_in       = (norm_x_acc == '0) || (norm_y_acc == '0);
  assign sq_in         = (state == S_CHK) ? norm_x_acc : norm_y_acc;
  assign sq_start      = ((state == S_CHK) && !zero_in) || ((state == S_SQX) && sq_done);
  assign out_load      = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  assign mag       = dot_acc[DOT_W-1] ? (~dot_acc + DOT_W'(1)) : dot_acc;
  assign num       = NUM_W'({mag, 16'h0000}) + NUM_W'(prod[D_W-1:0]);
  assign hi        = num[NUM_W-1:16];
  assign hi_ovf    = hi >= HI_W'({prod[D_W-1:0], 1'b0});
  assign div_trial = {rem, nlo[15]};
  assign div_fits  = div_trial >= {1'b0, den};

  always_comb begin
    mul_a = MUL_W'(xr);
    mul_b = MUL_W'(yr);
    if (state == S_MULD) begin
      mul_a = $signed({1'b0, sx});
      mul_b = $signed({1'b0, sy});
    end else if (phase == 2'd1) begin
      mul_b = MUL_W'(xr);
    end else if (phase == 2'd2) begin
      mul_a = MUL_W'(yr);
    end
  end

  always_comb begin
    if (zf) begin
      sim = '0;
    end else if (ovf) begin
      sim = neg ? SIM_MIN : SIM_MAX;
    end else if (neg) begin
      sim = (q > SIM_MIN) ? SIM_MIN : (~q + 16'd1);
    end else begin
      sim = (q > SIM_MAX) ? SIM_MAX : q;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (s_axis_tvalid) state_next = S_MAC;
      S_MAC:  if (phase == 2'd3) state_next = lastr ? S_CHK : S_IDLE;
      S_CHK:  state_next = zero_in ? S_OUT : S_SQX;
      S_SQX:  if (sq_done) state_next = S_SQY;
      S_SQY:  if (sq_done) state_next = S_MULD;
      S_MULD: state_next = S_NUM;
      S_NUM:  state_next = hi_ovf ? S_OUT : S_DIV;
      S_DIV:  if (cnt == 4'd0) state_next = S_OUT;
      S_OUT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= 2'd0;
      m_axis_tvalid <= 1'b0;
      dot_acc       <= '0;
      norm_x_acc    <= '0;
      norm_y_acc    <= '0;
    end else begin
      state <= state_next;
      phase <= (state == S_MAC) ? phase + 2'd1 : 2'd0;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
        dot_acc       <= '0;
        norm_x_acc    <= '0;
        norm_y_acc    <= '0;
      end else begin
        if (m_axis_tready) m_axis_tvalid <= 1'b0;
        if (state == S_MAC) begin
          case (phase)
            2'd1:    dot_acc    <= dot_acc + prod[DOT_W-1:0];
            2'd2:    norm_x_acc <= norm_x_acc + prod[NORM_W-1:0];
            2'd3:    norm_y_acc <= norm_y_acc + prod[NORM_W-1:0];
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (s_axis_tvalid && s_axis_tready) begin
      xr    <= s_axis_tdata[15:0];
      yr    <= s_axis_tdata[31:16];
      lastr <= s_axis_tlast;
    end
    if (state == S_CHK) begin
      zf  <= zero_in;
      ovf <= 1'b0;
      neg <= dot_acc[DOT_W-1];
    end
    if (state == S_SQX && sq_done) sx <= sq_root;
    if (state == S_SQY && sq_done) sy <= sq_root;
    if (state == S_NUM) begin
      den <= {prod[D_W-1:0], 1'b0};
      ovf <= hi_ovf;
      rem <= hi[DEN_W-1:0];
      nlo <= num[15:0];
      cnt <= 4'd15;
    end
    if (state == S_DIV) begin
      rem <= div_fits ? DEN_W'(div_trial - {1'b0, den}) : div_trial[DEN_W-1:0];
      q   <= {q[14:0], div_fits};
      nlo <= {nlo[14:0], 1'b0};
      cnt <= cnt - 4'd1;
    end
    if (out_load) begin
      m_axis_tdata <= sim;
      m_axis_tuser <= zf;
    end
  end

  a_zero_norm_sim: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 16'h0000))
    else $error("zero_norm result with nonzero similarity");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (dot_acc == '0 && norm_x_acc == '0 && norm_y_acc == '0))
    else $error("accumulators not cleared after result");

  a_sqrt_done_state: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_SQX || state == S_SQY))
    else $error("square root finished outside root states");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

endmodule

// File: rtl/csim_isqrt.sv
module csim_isqrt #(
  parameter int NORM_W = 41,
  parameter int ROOT_W = 21
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NORM_W-1:0] radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);

  localparam int R2_W = 2 * ROOT_W;

  logic              busy;
  logic [NORM_W-1:0] rem;
  logic [R2_W-1:0]   root_acc;
  logic [R2_W-1:0]   bitv;
  logic [R2_W:0]     trial;
  logic              fits;

  assign trial = {1'b0, root_acc} + {1'b0, bitv};
  assign fits  = (R2_W + 1)'(rem) >= trial;
  assign root  = root_acc[ROOT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && bitv[0]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= radicand;
      root_acc <= '0;
      bitv     <= R2_W'(1) << (R2_W - 2);
    end else if (busy) begin
      if (fits) begin
        rem      <= rem - trial[NORM_W-1:0];
        root_acc <= (root_acc >> 1) + bitv;
      end else begin
        root_acc <= root_acc >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule
